[rtl/core/dsl_pkg.sv]
// Shared types and codes for the descending sorted list block.
// No dependencies; compiled first.
package dsl_pkg;

  // command field of an input item
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_DUMP   = 2'd3;

  // status field of a result item
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // datapath operations issued by the controller
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_INSERT    = 3'd1;
  localparam logic [2:0] OP_CLEAR     = 3'd2;
  localparam logic [2:0] OP_DEL_STEP  = 3'd3;
  localparam logic [2:0] OP_DUMP_STEP = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic       load;   // latch key, clear removed and dump counters
  } dsl_cmd_t;

  typedef struct packed {
    logic space;        // result queue can take an item
    logic any_match;    // some stored entry equals the key
    logic occ_zero;     // store is empty
    logic dump_last;    // cell 0 holds the final dump value
  } dsl_stat_t;

  typedef struct packed {
    logic signed [31:0] item;
    logic [1:0]         status;
    logic [4:0]         count;
    logic [4:0]         removed;
    logic               last;
  } dsl_res_t;

endpackage

[rtl/core/dsl_in_if.sv]
// Command channel: valid/ready handshake with cmd and value payload.
// Depends on nothing.
interface dsl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

[rtl/core/dsl_out_if.sv]
// Result channel: valid/ready handshake with result payload.
// Depends on nothing.
interface dsl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] item;
  logic [1:0]         status;
  logic [4:0]         count;
  logic [4:0]         removed;
  logic               last;

  modport source (output valid, output item, output status, output count,
                  output removed, output last, input ready);
  modport sink   (input valid, input item, input status, input count,
                  input removed, input last, output ready);
endinterface

[rtl/core/descending_sorted_list.sv]
// Top level of the descending sorted list: controller plus cell-chain datapath.
// Depends on dsl_pkg, dsl_in_if, dsl_out_if, dsl_ctrl and dsl_dpath.
//
//   channel  dir  handshake      payload
//   in_i     in   valid / ready  cmd[1:0], value[31:0] signed
//   out_o    out  valid / ready  item[31:0] signed, status, count, removed, last
//
// Sequencing: insert and clear need no stepping; delete removes one matching
//   entry per cycle in the cell chain while the result queue has space, then
//   posts the result; dump sends one value per cycle while the queue has
//   space, rotated out of cell 0, or one empty result when the store is empty.
// Reset: occupancy and the result queue are cleared at once; stored values
//   are left as they are and need no sweep.
// Stalls: in_i is not ready while a delete or dump is stepping or while the
//   two-entry result queue is full; out_o stalls fill the queue and so also hold delete and dump steps.
module descending_sorted_list #(
  parameter int CAPACITY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsl_in_if.sink     in_i,
  dsl_out_if.source  out_o
);

  dsl_pkg::dsl_cmd_t  dcmd;
  dsl_pkg::dsl_stat_t dstat;
  dsl_pkg::dsl_res_t  dres;

  // command decode and delete/dump sequencing
  dsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .stat_i     (dstat),
    .cmd_o      (dcmd)
  );

  // sorted cells, counters and result queue
  dsl_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dcmd),
    .value_i     (in_i.value),
    .stat_o      (dstat),
    .res_valid_o (out_o.valid),
    .res_ready_i (out_o.ready),
    .res_o       (dres)
  );

  assign out_o.item    = dres.item;
  assign out_o.status  = dres.status;
  assign out_o.count   = dres.count;
  assign out_o.removed = dres.removed;
  assign out_o.last    = dres.last;

`ifndef SYNTHESIS
  localparam logic [4:0] CapCount = 5'(CAPACITY);

  // no new item is taken while the chain is stepping a delete or dump
  a_no_accept_while_stepping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dcmd.op == dsl_pkg::OP_DEL_STEP || dcmd.op == dsl_pkg::OP_DUMP_STEP)
      |-> !in_i.ready)
    else $error("input accepted during delete/dump sequencing");

  // only dump values other than the final one come without last
  a_nonlast_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last) |-> (out_o.status == dsl_pkg::ST_OK))
    else $error("non-final result with nonzero status");

  // a dropped insert reports a full store
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == dsl_pkg::ST_FULL) |-> (out_o.count == CapCount))
    else $error("full status with count below capacity");
`endif

endmodule

[rtl/core/dsl_ctrl.sv]
// Sequencer for the sorted list: decodes commands, steps delete and dump.
// Depends on dsl_pkg.
module dsl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_cmd_i,
  output logic                in_ready_o,
  input  dsl_pkg::dsl_stat_t  stat_i,
  output dsl_pkg::dsl_cmd_t   cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEL  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o.op   = dsl_pkg::OP_NONE;
    cmd_o.load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = stat_i.space;
        if (in_valid_i && stat_i.space) begin
          unique case (in_cmd_i)
            dsl_pkg::CMD_INSERT: cmd_o.op = dsl_pkg::OP_INSERT;
            dsl_pkg::CMD_CLEAR:  cmd_o.op = dsl_pkg::OP_CLEAR;
            dsl_pkg::CMD_DELETE: begin
              cmd_o.load = 1'b1;
              state_d    = S_DEL;
            end
            dsl_pkg::CMD_DUMP: begin
              cmd_o.load = 1'b1;
              state_d    = S_DUMP;
            end
          endcase
        end
      end
      S_DEL: begin
        // one match removed per step; final step posts the result
        if (stat_i.space) begin
          cmd_o.op = dsl_pkg::OP_DEL_STEP;
          if (!stat_i.any_match) state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat_i.space) begin
          cmd_o.op = dsl_pkg::OP_DUMP_STEP;
          if (stat_i.occ_zero || stat_i.dump_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/dsl_dpath.sv]
// Sorted cell chain, counters and two-entry result queue.
// Depends on dsl_pkg; driven by dsl_ctrl commands.
module dsl_dpath #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dsl_pkg::dsl_cmd_t  cmd_i,
  input  logic signed [31:0] value_i,
  output dsl_pkg::dsl_stat_t stat_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output dsl_pkg::dsl_res_t  res_o
);

  localparam int OW = $clog2(CAPACITY + 1);

  logic signed [31:0] ent_q [CAPACITY];
  logic signed [31:0] ins_nx [CAPACITY];
  logic signed [31:0] del_nx [CAPACITY];
  logic signed [31:0] rot_nx [CAPACITY];
  logic [CAPACITY-1:0] ge_v, eq_v, le_v, rot_v;

  logic [OW-1:0]      occ_q, rem_q, idx_q;
  logic signed [31:0] key_q;

  logic full, occ_zero, any_match, dump_last;
  logic do_ins, do_del, do_rot;

  assign full      = (occ_q == OW'(CAPACITY));
  assign occ_zero  = (occ_q == '0);
  assign any_match = |eq_v;
  assign dump_last = ((idx_q + OW'(1)) == occ_q);

  assign do_ins = (cmd_i.op == dsl_pkg::OP_INSERT) && !full;
  assign do_del = (cmd_i.op == dsl_pkg::OP_DEL_STEP) && any_match;
  assign do_rot = (cmd_i.op == dsl_pkg::OP_DUMP_STEP) && !occ_zero;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic valid;
    assign valid    = (OW'(i) < occ_q);
    assign ge_v[i]  = valid && (ent_q[i] >= value_i);
    assign eq_v[i]  = valid && (ent_q[i] == key_q);
    assign le_v[i]  = (ent_q[i] <= key_q);
    assign rot_v[i] = (OW'(i) == (occ_q - OW'(1)));

    if (i == 0) begin : g_head
      assign ins_nx[i] = ge_v[i] ? ent_q[i] : value_i;
    end else begin : g_body
      assign ins_nx[i] = ge_v[i] ? ent_q[i] : (ge_v[i-1] ? value_i : ent_q[i-1]);
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign del_nx[i] = ent_q[i];
      assign rot_nx[i] = ent_q[0];
    end else begin : g_mid
      // cells at or past the run of matches pull from their neighbor
      assign del_nx[i] = le_v[i] ? ent_q[i+1] : ent_q[i];
      // rotate within the occupied region only
      assign rot_nx[i] = rot_v[i] ? ent_q[0] : ent_q[i+1];
    end

    always_ff @(posedge clk_i) begin
      if (do_ins) begin
        ent_q[i] <= ins_nx[i];
      end else if (do_del) begin
        ent_q[i] <= del_nx[i];
      end else if (do_rot) begin
        ent_q[i] <= rot_nx[i];
      end
    end
  end

  // occupancy and sequencing counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      rem_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.load) begin
        rem_q <= '0;
        idx_q <= '0;
      end
      if (do_ins) begin
        occ_q <= occ_q + OW'(1);
      end else if (cmd_i.op == dsl_pkg::OP_CLEAR) begin
        occ_q <= '0;
      end else if (do_del) begin
        occ_q <= occ_q - OW'(1);
        rem_q <= rem_q + OW'(1);
      end else if (do_rot) begin
        idx_q <= dump_last ? '0 : idx_q + OW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) key_q <= value_i;
  end

  // result build
  logic [OW+4:0] occ_ext, occ_inc_ext, rem_ext;
  assign occ_ext     = {5'd0, occ_q};
  assign occ_inc_ext = {5'd0, occ_q + OW'(1)};
  assign rem_ext     = {5'd0, rem_q};

  logic              push;
  dsl_pkg::dsl_res_t push_res;

  always_comb begin
    push             = 1'b0;
    push_res.item    = '0;
    push_res.status  = dsl_pkg::ST_OK;
    push_res.count   = occ_ext[4:0];
    push_res.removed = '0;
    push_res.last    = 1'b1;
    case (cmd_i.op)
      dsl_pkg::OP_INSERT: begin
        push = 1'b1;
        if (full) begin
          push_res.status = dsl_pkg::ST_FULL;
        end else begin
          push_res.count = occ_inc_ext[4:0];
        end
      end
      dsl_pkg::OP_CLEAR: begin
        push           = 1'b1;
        push_res.count = '0;
      end
      dsl_pkg::OP_DEL_STEP: begin
        push             = !any_match;
        push_res.removed = rem_ext[4:0];
        if (rem_q == '0) begin
          push_res.status = occ_zero ? dsl_pkg::ST_EMPTY : dsl_pkg::ST_NOT_FOUND;
        end
      end
      dsl_pkg::OP_DUMP_STEP: begin
        push = 1'b1;
        if (occ_zero) begin
          push_res.status = dsl_pkg::ST_EMPTY;
        end else begin
          push_res.item = ent_q[0];
          push_res.last = dump_last;
        end
      end
      default: push = 1'b0;
    endcase
  end

  // two-entry result queue
  dsl_pkg::dsl_res_t q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] q_cnt_q;
  logic       pop;

  assign res_valid_o = (q_cnt_q != 2'd0);
  assign pop         = res_valid_o && res_ready_i;
  assign res_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= push_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      q_cnt_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      q_cnt_q <= q_cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign stat_o.space     = (q_cnt_q != 2'd2);
  assign stat_o.any_match = any_match;
  assign stat_o.occ_zero  = occ_zero;
  assign stat_o.dump_last = dump_last;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for descending_sorted_list: directed and random command items, checked against a
// scoreboard that keeps its own copy of the sorted store. Uses dsl_pkg, dsl_in_if, dsl_out_if.
module tb_top;

  localparam int CAP = 16;

  logic clk = 1'b0;
  logic rst_n;

  // calm flags switch off random idling on either side for a stretch of the run
  bit calm_in;
  bit calm_out;

  dsl_in_if  in_if ();
  dsl_out_if out_if ();

  descending_sorted_list #(.CAPACITY(CAP)) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirrors the store: entries kept largest first, duplicates after their equals.
  // Each accepted command appends the result items it should cause.
  class sorted_list_board;
    logic signed [31:0] stored[CAP];
    int                 held;
    dsl_pkg::dsl_res_t  awaited[$];
    int                 errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function void note_command(logic [1:0] c, logic signed [31:0] v);
      dsl_pkg::dsl_res_t r;
      int                pos;
      int                kept;
      int                gone;
      r      = '0;
      r.last = 1'b1;
      case (c)
        dsl_pkg::CMD_INSERT: begin
          if (held >= CAP) begin
            r.status = dsl_pkg::ST_FULL;
          end else begin
            pos = 0;
            while (pos < held && stored[pos] >= v) pos++;
            for (int i = held; i > pos; i--) stored[i] = stored[i-1];
            stored[pos] = v;
            held++;
            r.status = dsl_pkg::ST_OK;
          end
        end
        dsl_pkg::CMD_DELETE: begin
          if (held == 0) begin
            r.status = dsl_pkg::ST_EMPTY;
          end else begin
            kept = 0;
            gone = 0;
            for (int i = 0; i < held; i++) begin
              if (stored[i] == v) begin
                gone++;
              end else begin
                stored[kept] = stored[i];
                kept++;
              end
            end
            held      = kept;
            r.status  = (gone != 0) ? dsl_pkg::ST_OK : dsl_pkg::ST_NOT_FOUND;
            r.removed = 5'(gone);
          end
        end
        dsl_pkg::CMD_CLEAR: begin
          held     = 0;
          r.status = dsl_pkg::ST_OK;
        end
        default: begin
          if (held == 0) begin
            r.status = dsl_pkg::ST_EMPTY;
          end else begin
            // dump: one item per entry, last flag on the smallest
            for (int i = 0; i < held; i++) begin
              r.item   = stored[i];
              r.status = dsl_pkg::ST_OK;
              r.count  = 5'(held);
              r.last   = (i == held - 1);
              awaited.push_back(r);
            end
            return;
          end
        end
      endcase
      r.count = 5'(held);
      awaited.push_back(r);
    endfunction

    function void check_result(dsl_pkg::dsl_res_t got);
      dsl_pkg::dsl_res_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item=%0d status=%0d count=%0d removed=%0d last=%0d",
                 $time, got.item, got.status, got.count, got.removed, got.last);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch expected item=%0d status=%0d count=%0d removed=%0d last=%0d",
                 $time, want.item, want.status, want.count, want.removed, want.last);
        $display("%0t:          actual   item=%0d status=%0d count=%0d removed=%0d last=%0d",
                 $time, got.item, got.status, got.count, got.removed, got.last);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // some value currently held, so that deletes find matches
    function logic signed [31:0] pick_stored();
      return stored[$urandom_range(held - 1)];
    endfunction
  endclass

  sorted_list_board board = new();

  // about 13 in 100 items wait a short gap first
  function automatic int idle_gap();
    if (calm_in || $urandom_range(99) >= 13) return 0;
    return $urandom_range(1, 4);
  endfunction

  // values biased to a narrow band so inserts collide and deletes match
  function automatic logic signed [31:0] draw_value();
    int r;
    r = $urandom_range(99);
    if (r < 60) return int'($urandom_range(6)) - 3;
    if (r < 75) begin
      case ($urandom_range(3))
        0:       return 32'sh7fff_ffff;
        1:       return 32'sh8000_0000;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // Present one command item and hold it until accepted. valid stays high
  // on return so back-to-back items need no extra step.
  task automatic send_cmd(input logic [1:0] c, input logic signed [31:0] v);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      // payload is noise while valid is low
      repeat (gap) begin
        in_if.cmd   <= 2'($urandom);
        in_if.value <= $urandom;
        @(posedge clk);
      end
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= c;
    in_if.value <= v;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    board.note_command(c, v);
  endtask

  // Result side: check on each handshake, then choose the next ready.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid === 1'b1 && out_if.ready) begin
        board.check_result('{out_if.item, out_if.status, out_if.count,
                             out_if.removed, out_if.last});
      end
      out_if.ready <= calm_out || ($urandom_range(99) >= 13);
    end
  end

  // Run limit: far above the slowest legal run of this stimulus.
  initial begin
    #(200_000 * 12);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int               roll;
    logic [1:0]       c;
    logic signed [31:0] v;

    in_if.valid = 1'b0;
    in_if.cmd   = dsl_pkg::CMD_INSERT;
    in_if.value = '0;
    calm_in     = 1'b0;
    calm_out    = 1'b0;
    rst_n       = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-store cases first
    send_cmd(dsl_pkg::CMD_DUMP, 32'sd0);
    send_cmd(dsl_pkg::CMD_DELETE, 32'sd5);
    // extremes and a duplicate, then dump to see the order
    send_cmd(dsl_pkg::CMD_INSERT, 32'sh7fff_ffff);
    send_cmd(dsl_pkg::CMD_INSERT, 32'sh8000_0000);
    send_cmd(dsl_pkg::CMD_INSERT, 32'sd0);
    send_cmd(dsl_pkg::CMD_INSERT, -32'sd1);
    send_cmd(dsl_pkg::CMD_INSERT, 32'sd1);
    send_cmd(dsl_pkg::CMD_INSERT, 32'sd0);
    send_cmd(dsl_pkg::CMD_DUMP, 32'sd0);
    // delete with no match, then one removing both zeros
    send_cmd(dsl_pkg::CMD_DELETE, 32'sd5);
    send_cmd(dsl_pkg::CMD_DELETE, 32'sd0);
    // fill to capacity with one repeated value, then overflow
    repeat (CAP - 4) send_cmd(dsl_pkg::CMD_INSERT, 32'sd7);
    send_cmd(dsl_pkg::CMD_INSERT, 32'sd9);
    send_cmd(dsl_pkg::CMD_DUMP, 32'sd0);
    // delete of many equal entries at once
    send_cmd(dsl_pkg::CMD_DELETE, 32'sd7);
    send_cmd(dsl_pkg::CMD_CLEAR, 32'sd0);
    send_cmd(dsl_pkg::CMD_DUMP, 32'sd0);

    // Random: insert-heavy so the store fills up and sits near capacity
    for (int k = 0; k < 160; k++) begin
      calm_in  = (k >= 60 && k < 100);
      calm_out = calm_in;
      roll = $urandom_range(99);
      if (roll < 55)      c = dsl_pkg::CMD_INSERT;
      else if (roll < 77) c = dsl_pkg::CMD_DELETE;
      else if (roll < 94) c = dsl_pkg::CMD_DUMP;
      else                c = dsl_pkg::CMD_CLEAR;
      v = draw_value();
      if (c == dsl_pkg::CMD_DELETE && board.held > 0 && $urandom_range(99) < 70)
        v = board.pick_stored();
      send_cmd(c, v);
    end
    calm_in  = 1'b0;
    calm_out = 1'b0;
    in_if.valid <= 1'b0;

    // drain, then allow a full dump's worth of cycles for stray results
    while (board.pending() != 0) @(posedge clk);
    repeat (CAP + 8) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
